/* design/crb_pkg.sv */
package crb_pkg;

    localparam int LINE_MAX      = 50;
    localparam int PACKAGE_BYTES = 20;
    localparam int STORE_DEPTH   = 64;
    localparam int ADDR_W        = 6;
    localparam int CNT_W         = 5;
    localparam int SCAN_LIMIT    = STORE_DEPTH - 3;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  CH_STAR  = 8'h2A;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [6:0]  B64_PAD  = 7'd64;
    localparam logic [6:0]  B64_BAD  = 7'd127;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_START = 2'd1;
    localparam logic [1:0] ST_CRC      = 2'd2;
    localparam logic [1:0] ST_DECODE   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TERM,
        S_CHK0,
        S_SCAN,
        S_CRC,
        S_VAL,
        S_DEC,
        S_COPY,
        S_OUT
    } state_t;

    // one crc byte step, eight shift/xor iterations
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // 0..63 for alphabet, pad code for '=', bad code otherwise
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] v;
        v = B64_BAD;
        if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B) v = 7'd62;
        else if (c == 8'h2F) v = 7'd63;
        else if (c == 8'h3D) v = B64_PAD;
        return v;
    endfunction

endpackage

/* design/crb_ram.sv */
module crb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

/* design/crc_checked_base64_frame_receiver.sv */
// a data byte or carriage return leaves the input ready for the next byte
// a newline blocks the input while the line is checked and decoded and until the
//   result is taken, so lines go one at a time; early rejects are shorter
// throughput: one byte per cycle for data, held off during a newline or the store clear
// reset: control clears at once; the line store is then cleared by a pass over the
//   whole store after reset, during which no request is accepted
module crc_checked_base64_frame_receiver (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // [1:0] frame_status, [6:2] decoded_count,
                                    // [70:7] package_low, [134:71] package_middle,
                                    // [166:135] package_high, [167] zero
);
    import crb_pkg::*;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] wpos_reg, wpos_next;
    logic [ADDR_W:0]   idx_reg, idx_next;     // scan / walk index
    logic [ADDR_W:0]   end_reg, end_next;
    logic [15:0]       crc_reg, crc_next;
    logic [1:0]        pads_reg, pads_next;
    logic              bad_reg, bad_next;
    logic [23:0]       acc_reg, acc_next;
    logic [1:0]        qpos_reg, qpos_next;
    logic [CNT_W:0]    o_reg, o_next;
    logic [CNT_W:0]    out_reg, out_next;
    logic [1:0]        status_reg, status_next;
    logic [7:0]        tmp_reg [PACKAGE_BYTES];
    logic [7:0]        pkg_reg [PACKAGE_BYTES];
    logic              rd_pend_reg, rd_pend_next;
    logic              clr_reg, clr_next;
    logic [ADDR_W:0]   clr_cnt_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]        wdata, rdata;
    logic              acc_in;
    logic [6:0]        bv;
    logic [ADDR_W:0]   n_text;
    logic              tmp_we, copy;
    logic [23:0]       acc_sh;

    crb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign acc_in   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !clr_reg;
    assign bv       = b64_value(rdata);
    assign n_text   = end_reg - 7'd1;
    assign acc_sh   = {acc_reg[17:0], ((bv == B64_PAD) ? 6'd0 : bv[5:0])};

    // result packing
    always_comb
    begin
        m_tdata      = '0;
        m_tdata[1:0] = status_reg;
        m_tdata[6:2] = out_reg[CNT_W-1:0];
        for (int i = 0; i < PACKAGE_BYTES; i++)
            m_tdata[7 + 8 * i +: 8] = pkg_reg[i];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wpos_reg    <= '0;
            rd_pend_reg <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            rd_pend_reg <= rd_pend_next;
            clr_reg     <= clr_next;
            if (clr_reg)
                clr_cnt_reg <= clr_cnt_reg + 7'd1;
        end
    end

    // package store, reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PACKAGE_BYTES; i++)
                pkg_reg[i] <= '0;
        end
        else if (copy)
        begin
            for (int i = 0; i < PACKAGE_BYTES; i++)
                if (CNT_W'(i) < out_reg[CNT_W-1:0] || out_reg[CNT_W])
                    pkg_reg[i] <= tmp_reg[i];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        end_reg    <= end_next;
        crc_reg    <= crc_next;
        pads_reg   <= pads_next;
        bad_reg    <= bad_next;
        acc_reg    <= acc_next;
        qpos_reg   <= qpos_next;
        o_reg      <= o_next;
        out_reg    <= out_next;
        status_reg <= status_next;
        if (tmp_we)
            for (int k = 0; k < 3; k++)
                if (o_reg + 6'(k) < out_reg)
                    tmp_reg[CNT_W'(o_reg + 6'(k))] <= acc_sh[23 - 8 * k -: 8];
    end

    // sequencer: one store byte per cycle through the crc / base64 functions
    always_comb
    begin
        state_next   = state_reg;
        wpos_next    = wpos_reg;
        idx_next     = idx_reg;
        end_next     = end_reg;
        crc_next     = crc_reg;
        pads_next    = pads_reg;
        bad_next     = bad_reg;
        acc_next     = acc_reg;
        qpos_next    = qpos_reg;
        o_next       = o_reg;
        out_next     = out_reg;
        status_next  = status_reg;
        rd_pend_next = 1'b0;
        clr_next     = clr_reg && (clr_cnt_reg != 7'(STORE_DEPTH - 1));
        we           = 1'b0;
        waddr        = wpos_reg;
        wdata        = s_tdata;
        raddr        = idx_reg[ADDR_W-1:0];
        tmp_we       = 1'b0;
        copy         = 1'b0;
        m_tvalid     = 1'b0;
        if (clr_reg)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg[ADDR_W-1:0];
            wdata = '0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (acc_in && s_tdata == CH_LF)
                begin
                    we        = 1'b1;
                    wdata     = '0;
                    wpos_next = '0;
                    state_next = S_TERM;
                end
                else if (acc_in && s_tdata != CH_CR &&
                         wpos_reg < ADDR_W'(LINE_MAX - 1))
                begin
                    we        = 1'b1;
                    wpos_next = wpos_reg + 6'd1;
                end
            end
            S_TERM:
            begin
                raddr      = '0;
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                // rdata is byte 0
                crc_next = crc_step(16'h0000, rdata);
                if (rdata != CH_STAR)
                begin
                    status_next = ST_NO_START;
                    out_next    = '0;
                    state_next  = S_OUT;
                end
                else
                begin
                    idx_next     = 7'd1;
                    raddr        = 6'd1;
                    rd_pend_next = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rdata is byte idx; crc folds bytes as they pass
                if (idx_reg >= 7'(SCAN_LIMIT) || rdata == CH_STAR || rdata == 8'h00)
                begin
                    end_next   = idx_reg;
                    state_next = S_CRC;
                    crc_next   = crc_step(crc_reg, rdata);
                    idx_next   = idx_reg + 7'd1;
                    raddr      = 6'(idx_reg + 7'd1);
                end
                else
                begin
                    crc_next = crc_step(crc_reg, rdata);
                    idx_next = idx_reg + 7'd1;
                    raddr    = 6'(idx_reg + 7'd1);
                end
            end
            S_CRC:
            begin
                // two bytes after the end mark
                crc_next = crc_step(crc_reg, rdata);
                idx_next = idx_reg + 7'd1;
                raddr    = 6'(idx_reg + 7'd1);
                if (idx_reg == end_reg + 7'd2)
                begin
                    idx_next  = 7'd1;
                    raddr     = 6'd1;
                    pads_next = '0;
                    bad_next  = (n_text[1:0] != 2'b00);
                    state_next = S_VAL;
                    if (crc_next != 16'h0000)
                    begin
                        status_next = ST_CRC;
                        out_next    = '0;
                        state_next  = S_OUT;
                    end
                end
            end
            S_VAL:
            begin
                // rdata is byte idx; validity over text positions 1..end-1
                if (idx_reg >= end_reg)
                begin
                    out_next = 6'(({1'b0, n_text} >> 2) * 3) - 6'(pads_reg);
                    if (bad_reg || 6'(({1'b0, n_text} >> 2) * 3) - 6'(pads_reg)
                        > 6'(PACKAGE_BYTES))
                    begin
                        status_next = ST_DECODE;
                        out_next    = '0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        idx_next   = 7'd1;
                        raddr      = 6'd1;
                        qpos_next  = '0;
                        o_next     = '0;
                        acc_next   = '0;
                        state_next = S_DEC;
                    end
                end
                else
                begin
                    if (bv == B64_BAD)
                        bad_next = 1'b1;
                    else if (bv == B64_PAD)
                    begin
                        if (idx_reg + 7'd1 < end_reg - 7'd1)
                            bad_next = 1'b1;
                        pads_next = pads_reg + 2'd1;
                    end
                    else if (pads_reg != 2'd0)
                        bad_next = 1'b1;
                    idx_next = idx_reg + 7'd1;
                    raddr    = 6'(idx_reg + 7'd1);
                end
            end
            S_DEC:
            begin
                // shift in sextets, emit up to three bytes per quantum
                if (idx_reg >= end_reg)
                begin
                    status_next = ST_OK;
                    state_next  = S_COPY;
                end
                else if (qpos_reg == 2'd3 && rd_pend_reg)
                begin
                    acc_next  = acc_sh;
                    tmp_we    = 1'b1;
                    o_next    = (o_reg + 6'd3 < out_reg) ? o_reg + 6'd3 : out_reg;
                    qpos_next = 2'd0;
                    idx_next  = idx_reg + 7'd1;
                    raddr     = 6'(idx_reg + 7'd1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    acc_next  = acc_sh;
                    qpos_next = qpos_reg + 2'd1;
                    idx_next  = idx_reg + 7'd1;
                    raddr     = 6'(idx_reg + 7'd1);
                    rd_pend_next = 1'b1;
                end
            end
            S_COPY:
            begin
                copy       = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));

    // input and result never open together
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid));

    // no request during the clearing pass
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !s_tready);

    // count bounded by the package size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:2] <= 5'(PACKAGE_BYTES));

    // rejected frames report no bytes
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[6:2] == 5'd0);

endmodule

/* bench/crc_checked_base64_frame_receiver_test.sv */
module crc_checked_base64_frame_receiver_test;
    import crb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  count;
        logic [63:0] pkg_low;
        logic [63:0] pkg_mid;
        logic [31:0] pkg_high;
    } frame_result_t;

    typedef enum int {FL_NONE, FL_CRC, FL_CHAR, FL_LEN, FL_START} flaw_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;

    // predictor state
    logic [7:0]    line_mem [STORE_DEPTH];
    logic [5:0]    line_wpos;
    logic [7:0]    pkg_mem [PACKAGE_BYTES];
    frame_result_t frame_queue [$];
    logic [7:0]    byte_queue [$];
    int            snd_idle;
    int            rcv_idle;
    int            errors;
    int            cycles;

    crc_checked_base64_frame_receiver u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // crc-16 xmodem, bit at a time
    function automatic logic [15:0] xmodem_next(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ b[k];
            c = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // -1 for illegal, 64 for pad
    function automatic int sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return c - "A";
        if (c >= "a" && c <= "z") return c - "a" + 26;
        if (c >= "0" && c <= "9") return c - "0" + 52;
        if (c == "+") return 62;
        if (c == "/") return 63;
        if (c == "=") return 64;
        return -1;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    // decode line positions 1..n into the package, -1 on error
    function automatic int unpack_text(input int n);
        logic [7:0] tmp [PACKAGE_BYTES];
        int pads, outn, o, v;
        logic [23:0] acc;
        pads = 0;
        o = 0;
        if (n % 4 != 0) return -1;
        for (int i = 0; i < n; i++)
        begin
            v = sextet_of(line_mem[(1 + i) % STORE_DEPTH]);
            if (v < 0) return -1;
            if (v == 64)
            begin
                if (i + 2 < n) return -1;
                pads++;
            end
            else if (pads != 0)
                return -1;
        end
        outn = (n / 4) * 3 - pads;
        if (outn > PACKAGE_BYTES) return -1;
        for (int i = 0; i < n; i += 4)
        begin
            acc = '0;
            for (int k = 0; k < 4; k++)
            begin
                v = sextet_of(line_mem[(1 + i + k) % STORE_DEPTH]);
                if (v == 64) v = 0;
                acc = {acc[17:0], 6'(v)};
            end
            for (int k = 0; k < 3; k++)
                if (o < outn)
                begin
                    tmp[o] = acc[23 - 8 * k -: 8];
                    o++;
                end
        end
        for (int i = 0; i < outn; i++)
            pkg_mem[i] = tmp[i];
        return outn;
    endfunction

    // advance the framer model by one byte, returns 1 when a result is due
    function automatic bit frame_predict(input logic [7:0] b, output frame_result_t r);
        int stop, dec;
        logic [15:0] c;
        r = '0;
        if (b == CH_CR) return 0;
        if (b != CH_LF)
        begin
            if (line_wpos < LINE_MAX - 1)
            begin
                line_mem[line_wpos] = b;
                line_wpos = line_wpos + 6'd1;
            end
            return 0;
        end
        line_mem[line_wpos] = 8'h00;
        line_wpos = '0;
        if (line_mem[0] != CH_STAR)
            r.status = ST_NO_START;
        else
        begin
            stop = 1;
            while (stop < SCAN_LIMIT && line_mem[stop] != CH_STAR && line_mem[stop] != 8'h00)
                stop++;
            c = '0;
            for (int i = 0; i < stop + 3; i++)
                c = xmodem_next(c, line_mem[i % STORE_DEPTH]);
            if (c != 0)
                r.status = ST_CRC;
            else
            begin
                dec = unpack_text(stop - 1);
                if (dec < 0)
                    r.status = ST_DECODE;
                else
                begin
                    r.status = ST_OK;
                    r.count = 5'(dec);
                end
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            r.pkg_low[8 * i +: 8] = pkg_mem[i];
            r.pkg_mid[8 * i +: 8] = pkg_mem[8 + i];
        end
        for (int i = 0; i < 4; i++)
            r.pkg_high[8 * i +: 8] = pkg_mem[16 + i];
        return 1;
    endfunction

    // queue one framed line; fill < 0 means random payload bytes
    task automatic add_frame(input int nbytes, input flaw_t flaw, input int fill);
        logic [7:0] line [$];
        logic [7:0] raw [$];
        logic [7:0] junk [5];
        logic [23:0] g;
        logic [15:0] c;
        int p;
        junk = '{" ", "-", ".", "#", "@"};
        for (int i = 0; i < nbytes; i++)
            raw.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
        line.push_back(CH_STAR);
        for (int i = 0; i < nbytes; i += 3)
        begin
            g = {raw[i], (i + 1 < nbytes) ? raw[i + 1] : 8'h00,
                 (i + 2 < nbytes) ? raw[i + 2] : 8'h00};
            line.push_back(sextet_char(g[23:18]));
            line.push_back(sextet_char(g[17:12]));
            line.push_back((i + 1 < nbytes) ? sextet_char(g[11:6]) : "=");
            line.push_back((i + 2 < nbytes) ? sextet_char(g[5:0]) : "=");
        end
        if (flaw == FL_CHAR)
        begin
            p = (line.size() > 1) ? $urandom_range(line.size() - 1, 1) : 1;
            if (line.size() > 1)
                line[p] = junk[$urandom_range(4)];
            else
                line.push_back(junk[$urandom_range(4)]);
        end
        if (flaw == FL_LEN && line.size() > 1)
            void'(line.pop_back());
        else if (flaw == FL_LEN)
            line.push_back("Q");
        line.push_back(CH_STAR);
        c = '0;
        foreach (line[i])
            c = xmodem_next(c, line[i]);
        if (flaw == FL_CRC)
            c[$urandom_range(15)] ^= 1'b1;
        line.push_back(c[15:8]);
        line.push_back(c[7:0]);
        if (flaw == FL_START)
            line[0] = "A";
        foreach (line[i])
        begin
            if ($urandom_range(99) < 4)
                byte_queue.push_back(CH_CR);
            byte_queue.push_back(line[i]);
        end
        byte_queue.push_back(CH_LF);
    endtask

    task automatic add_noise(input int len, input bit close);
        for (int i = 0; i < len; i++)
            byte_queue.push_back(8'($urandom_range(255)));
        if (close)
            byte_queue.push_back(CH_LF);
    endtask

    task automatic add_random(input int target);
        int start, r, n;
        flaw_t fl;
        start = byte_queue.size();
        while (byte_queue.size() - start < target)
        begin
            r = $urandom_range(99);
            n = ($urandom_range(9) == 0) ? $urandom_range(21, 16) : $urandom_range(15);
            if (r < 70)
                add_frame(n, FL_NONE, -1);
            else if (r < 85)
            begin
                fl = flaw_t'($urandom_range(4, 1));
                add_frame(n, fl, -1);
            end
            else
                add_noise($urandom_range(60, 1), $urandom_range(3) != 0);
        end
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || s_tvalid || frame_queue.size() != 0)
            @(posedge clk);
    endtask

    // mismatch report
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // byte sender
    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t r;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                if (frame_predict(s_tdata, r))
                    frame_queue.push_back(r);
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= snd_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_queue.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
            if (m_tvalid && m_tready)
            begin
                if (frame_queue.size() == 0)
                    report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
                else
                begin
                    want = frame_queue.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("frame_status", 64'(m_tdata[1:0]),
                                        64'(want.status));
                    if (m_tdata[6:2] !== want.count)
                        report_mismatch("decoded_count", 64'(m_tdata[6:2]),
                                        64'(want.count));
                    if (m_tdata[70:7] !== want.pkg_low)
                        report_mismatch("package_low", m_tdata[70:7], want.pkg_low);
                    if (m_tdata[134:71] !== want.pkg_mid)
                        report_mismatch("package_middle", m_tdata[134:71], want.pkg_mid);
                    if (m_tdata[166:135] !== want.pkg_high)
                        report_mismatch("package_high", 64'(m_tdata[166:135]),
                                        64'(want.pkg_high));
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        snd_idle = 12;
        rcv_idle = 81;
        line_wpos = '0;
        foreach (line_mem[i])
            line_mem[i] = 8'h00;
        foreach (pkg_mem[i])
            pkg_mem[i] = 8'h00;

        // directed: empty text, full and oversize payloads, pads, flaws, long line
        add_frame(0, FL_NONE, -1);
        add_frame(20, FL_NONE, 255);
        add_frame(20, FL_NONE, 0);
        add_frame(21, FL_NONE, 85);
        add_frame(1, FL_NONE, -1);
        add_frame(2, FL_NONE, -1);
        add_frame(6, FL_CHAR, -1);
        add_frame(6, FL_CRC, -1);
        add_frame(3, FL_LEN, -1);
        add_frame(3, FL_START, -1);
        byte_queue.push_back(CH_LF);
        for (int i = 0; i < 60; i++)
            byte_queue.push_back("A");
        byte_queue.push_back(CH_LF);
        add_frame(4, FL_NONE, -1);
        add_random(400);
        wait_drained();

        // hold the sender back until every result is in, then swap idling
        snd_idle = 81;
        rcv_idle = 12;
        add_random(400);
        wait_drained();

        snd_idle = 0;
        rcv_idle = 0;
        add_random(400);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && frame_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
